// ===== hdl/olpe_pkg.sv =====
`default_nettype none
package olpe_pkg;

	localparam int OLPE_CAPACITY = 16;
	localparam int OLPE_VALUE_W  = 32;
	localparam int OLPE_POS_W    = 5;
	localparam int OLPE_COUNT_W  = 5;

	typedef enum logic [2:0] {
		CMD_INS_FIRST = 3'd0,
		CMD_INS_LAST  = 3'd1,
		CMD_INS_AT    = 3'd2,
		CMD_DEL_FIRST = 3'd3,
		CMD_DEL_LAST  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_DUMP      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_WALK,
		S_DRAIN,
		S_COMMIT,
		S_REPORT
	} state_t;

	typedef struct packed {
		cmd_t                           cmd;
		logic signed [OLPE_VALUE_W-1:0] value;
		logic [OLPE_POS_W-1:0]          position;
	} olpe_req_t;

	typedef struct packed {
		status_t                        status;
		logic [OLPE_COUNT_W-1:0]        count;
		logic signed [OLPE_VALUE_W-1:0] element;
		logic                           last;
	} olpe_rsp_t;

	typedef struct packed {
		logic capture;
		logic plan;
		logic walk;
		logic commit;
		logic report;
	} olpe_ctl_t;

	typedef struct packed {
		logic is_dump;
		logic direct;
		logic no_move;
		logic at_end;
	} olpe_stat_t;

endpackage
`default_nettype wire

// ===== hdl/ordered_list_positional_edit_core.sv =====
// Bounded ordered list of signed 32-bit values with positional insert and delete.
// Request channel: drive req and raise start; the request is taken at a rising
// edge where start is high and busy is low. busy stays high until the request
// has finished its work.
// Result channel: each result is on the result port for one cycle, marked by
// done. The receiver cannot stall, so results are never held back.
// An edit gives one status result with the new count. A dump gives one result
// per entry, in order, with last set on the final one; an empty list or an
// error gives a single status result.
// After the accepting edge, an error or an unused command goes from DECIDE
// straight to REPORT; an edit that moves nothing goes through COMMIT to REPORT;
// an edit that moves entries (from the edit point to the end of the list) walks
// them in WALK, then passes DRAIN, COMMIT and REPORT. A dump walks its entries,
// showing them one per cycle, and ends after DRAIN. busy drops in the cycle of
// the final result, so the next request can be taken at the edge that ends it;
// the slowest requests, an insert at the front of a list one short of full or a
// delete at the front of a full list, hold the block longest. Entries move one
// per cycle through the entry RAM (one write port, one registered read port).
// Reset clears the count and all control state; the entry RAM is not cleared,
// since only written entries are ever read.
`default_nettype none
module ordered_list_positional_edit_core
	import olpe_pkg::*;
#(
	parameter int CAPACITY = OLPE_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire olpe_req_t req,
	output logic           busy,
	output logic           done,
	output olpe_rsp_t      result
);

	olpe_ctl_t  ctl;
	olpe_stat_t stat;

	olpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy)
	);

	olpe_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.req    (req),
		.stat   (stat),
		.done   (done),
		.result (result)
	);

endmodule
`default_nettype wire

// ===== hdl/olpe_ram.sv =====
`default_nettype none
module olpe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hdl/olpe_ctrl.sv =====
`default_nettype none
module olpe_ctrl
	import olpe_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire olpe_stat_t stat,
	output olpe_ctl_t       ctl,
	output logic            busy
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.direct) begin
					state_d = S_REPORT;
				end else if (stat.is_dump) begin
					state_d = S_WALK;
				end else if (stat.no_move) begin
					state_d = S_COMMIT;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				if (stat.at_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = stat.is_dump ? S_IDLE : S_COMMIT;
			end
			S_COMMIT: begin
				state_d = S_REPORT;
			end
			S_REPORT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl     = '0;
		busy    = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy        = 1'b0;
				ctl.capture = start;
			end
			S_DECIDE: begin
				ctl.plan = 1'b1;
			end
			S_WALK: begin
				ctl.walk = 1'b1;
			end
			S_DRAIN: begin
				ctl = '0;
			end
			S_COMMIT: begin
				ctl.commit = 1'b1;
			end
			S_REPORT: begin
				ctl.report = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/olpe_dp.sv =====
`default_nettype none
module olpe_dp
	import olpe_pkg::*;
#(
	parameter int CAPACITY = OLPE_CAPACITY
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire olpe_ctl_t ctl,
	input  wire olpe_req_t req,
	output olpe_stat_t     stat,
	output logic           done,
	output olpe_rsp_t      result
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = ((CW > OLPE_POS_W) ? CW : OLPE_POS_W) + 1;

	cmd_t                           cmd_q;
	logic signed [OLPE_VALUE_W-1:0] value_q;
	logic [OLPE_POS_W-1:0]          kin_q;
	logic [CW-1:0]                  count_q;
	logic [IW-1:0]                  k_q;
	logic [IW-1:0]                  ptr_q;
	logic [IW-1:0]                  end_q;
	status_t                        status_q;
	logic                           pend_s1;
	logic [IW-1:0]                  dst_s1;
	logic                           last_s1;
	logic                           done_q;
	olpe_rsp_t                      result_q;

	logic                    is_ins;
	logic                    is_del;
	logic                    is_dump;
	logic [WW-1:0]           cnt_w;
	logic [WW-1:0]           kin_w;
	logic [WW-1:0]           k_eff;
	status_t                 stat_code;
	logic                    full;
	logic                    empty;
	logic                    ram_we;
	logic [IW-1:0]           ram_waddr;
	logic [OLPE_VALUE_W-1:0] ram_wdata;
	logic [OLPE_VALUE_W-1:0] ram_rdata;

	assign is_ins  = (cmd_q == CMD_INS_FIRST) || (cmd_q == CMD_INS_LAST) ||
		(cmd_q == CMD_INS_AT);
	assign is_del  = (cmd_q == CMD_DEL_FIRST) || (cmd_q == CMD_DEL_LAST) ||
		(cmd_q == CMD_DEL_AT);
	assign is_dump = (cmd_q == CMD_DUMP);
	assign cnt_w   = WW'(count_q);
	assign kin_w   = WW'(kin_q);
	assign full    = (count_q >= CW'(CAPACITY));
	assign empty   = (count_q == '0);

	always_comb begin
		case (cmd_q)
			CMD_INS_LAST:  k_eff = cnt_w;
			CMD_INS_AT:    k_eff = kin_w;
			CMD_DEL_LAST:  k_eff = cnt_w - WW'(1);
			CMD_DEL_AT:    k_eff = kin_w;
			default:       k_eff = '0;
		endcase
	end

	always_comb begin
		stat_code = STAT_OK;
		if (is_ins) begin
			if (full) begin
				stat_code = STAT_FULL;
			end else if ((cmd_q == CMD_INS_AT) && (kin_w > cnt_w)) begin
				stat_code = STAT_RANGE;
			end
		end else if (is_del) begin
			if (empty) begin
				stat_code = STAT_EMPTY;
			end else if ((cmd_q == CMD_DEL_AT) && (kin_w >= cnt_w)) begin
				stat_code = STAT_RANGE;
			end
		end else if (is_dump) begin
			if (empty) begin
				stat_code = STAT_EMPTY;
			end
		end
	end

	assign stat.is_dump = is_dump;
	assign stat.direct  = (stat_code != STAT_OK) || !(is_ins || is_del || is_dump);
	assign stat.no_move = is_ins ? (k_eff == cnt_w) : ((k_eff + WW'(1)) == cnt_w);
	assign stat.at_end  = (ptr_q == end_q);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q   <= req.cmd;
			value_q <= req.value;
			kin_q   <= (req.position == '0) ? '0 : req.position - OLPE_POS_W'(1);
		end
		if (ctl.plan) begin
			status_q <= stat_code;
			k_q      <= IW'(k_eff);
			if (is_ins) begin
				ptr_q <= IW'(cnt_w - WW'(1));
				end_q <= IW'(k_eff);
			end else if (is_del) begin
				ptr_q <= IW'(k_eff + WW'(1));
				end_q <= IW'(cnt_w - WW'(1));
			end else begin
				ptr_q <= '0;
				end_q <= IW'(cnt_w - WW'(1));
			end
		end else if (ctl.walk) begin
			ptr_q <= is_ins ? ptr_q - IW'(1) : ptr_q + IW'(1);
		end
		dst_s1  <= is_ins ? ptr_q + IW'(1) : ptr_q - IW'(1);
		last_s1 <= (ptr_q == end_q);
		if (ctl.report) begin
			result_q.status  <= status_q;
			result_q.count   <= OLPE_COUNT_W'(count_q);
			result_q.element <= '0;
			result_q.last    <= 1'b1;
		end else begin
			result_q.status  <= STAT_OK;
			result_q.count   <= OLPE_COUNT_W'(count_q);
			result_q.element <= ram_rdata;
			result_q.last    <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pend_s1 <= ctl.walk;
			done_q  <= (pend_s1 && is_dump) || ctl.report;
			if (ctl.commit) begin
				count_q <= is_ins ? count_q + CW'(1) : count_q - CW'(1);
			end
		end
	end

	assign ram_we    = (pend_s1 && !is_dump) || (ctl.commit && is_ins);
	assign ram_waddr = ctl.commit ? k_q : dst_s1;
	assign ram_wdata = ctl.commit ? value_q : ram_rdata;

	olpe_ram #(
		.WIDTH (OLPE_VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
module testbench;
	import olpe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam cmd_t CMD_NOP = cmd_t'(3'd7);
	localparam int DRAIN_CYCLES = OLPE_CAPACITY + 10;
	localparam int PHASE_ITEMS = 100;

	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	typedef struct {
		olpe_req_t req;
		bit        drain_first;
	} pend_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	olpe_req_t req = '0;
	logic      busy;
	logic      done;
	olpe_rsp_t result;

	pend_t     pending_q[$];
	olpe_rsp_t rsp_due_q[$];
	logic signed [OLPE_VALUE_W-1:0] list_vals[OLPE_CAPACITY];
	int        list_len = 0;
	int        gen_len = 0;
	int        idle_pct = 6;
	int        errors = 0;

	ordered_list_positional_edit_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one request to the list and queue the results it should produce.
	function automatic void apply_request(olpe_req_t r);
		int p;
		int slot;
		olpe_rsp_t s;
		p = (r.position == 0) ? 1 : int'(r.position);
		s = '0;
		s.status = STAT_OK;
		s.last = 1'b1;
		case (r.cmd)
			CMD_INS_FIRST, CMD_INS_LAST, CMD_INS_AT: begin
				if (list_len >= OLPE_CAPACITY) begin
					s.status = STAT_FULL;
				end else if (r.cmd == CMD_INS_AT && p > list_len + 1) begin
					s.status = STAT_RANGE;
				end else begin
					slot = (r.cmd == CMD_INS_FIRST) ? 0 :
						(r.cmd == CMD_INS_LAST) ? list_len : p - 1;
					for (int i = list_len; i > slot; i--)
						list_vals[i] = list_vals[i-1];
					list_vals[slot] = r.value;
					list_len++;
				end
			end
			CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
				if (list_len == 0) begin
					s.status = STAT_EMPTY;
				end else if (r.cmd == CMD_DEL_AT && p > list_len) begin
					s.status = STAT_RANGE;
				end else begin
					slot = (r.cmd == CMD_DEL_FIRST) ? 0 :
						(r.cmd == CMD_DEL_LAST) ? list_len - 1 : p - 1;
					for (int i = slot; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
				end
			end
			CMD_DUMP: begin
				if (list_len == 0) begin
					s.status = STAT_EMPTY;
				end else begin
					for (int i = 0; i < list_len; i++) begin
						s.count = list_len[OLPE_COUNT_W-1:0];
						s.element = list_vals[i];
						s.last = (i + 1 == list_len);
						rsp_due_q.push_back(s);
					end
					return;
				end
			end
			default: begin
			end
		endcase
		s.count = list_len[OLPE_COUNT_W-1:0];
		rsp_due_q.push_back(s);
	endfunction

	// Queue one request, and track the list length on the generator side to aim positions.
	function automatic void queue_req(cmd_t c, logic signed [OLPE_VALUE_W-1:0] v, int pos,
			bit drain = 1'b0);
		pend_t it;
		int p;
		it.req.cmd = c;
		it.req.value = v;
		it.req.position = pos[OLPE_POS_W-1:0];
		it.drain_first = drain;
		pending_q.push_back(it);
		p = (pos == 0) ? 1 : pos;
		if (c == CMD_INS_FIRST || c == CMD_INS_LAST || c == CMD_INS_AT) begin
			if (gen_len < OLPE_CAPACITY && (c != CMD_INS_AT || p <= gen_len + 1))
				gen_len++;
		end else if (c == CMD_DEL_FIRST || c == CMD_DEL_LAST || c == CMD_DEL_AT) begin
			if (gen_len > 0 && (c != CMD_DEL_AT || p <= gen_len))
				gen_len--;
		end
	endfunction

	function automatic logic signed [OLPE_VALUE_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_pos();
		if ($urandom_range(99) < 85)
			return $urandom_range(gen_len + 1, 0);
		return $urandom_range(17, 0);
	endfunction

	function automatic void random_req(mix_t mix, bit drain);
		int r;
		int ins_pct;
		cmd_t c;
		r = $urandom_range(99);
		ins_pct = (mix == MIX_GROW) ? 80 : (mix == MIX_SHRINK) ? 15 : 45;
		if (r < 10)
			c = CMD_DUMP;
		else if (r < 10 + ins_pct * 90 / 100)
			c = cmd_t'($urandom_range(2, 0));
		else
			c = cmd_t'($urandom_range(5, 3));
		queue_req(c, pick_value(), pick_pos(), drain);
	endfunction

	task automatic wait_drained();
		while (pending_q.size() != 0 || start || rsp_due_q.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else begin
			if (start && !busy)
				apply_request(req);
			if (!start || !busy) begin
				if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct &&
						(!pending_q[0].drain_first ||
						(rsp_due_q.size() == 0 && !done))) begin
					start <= 1'b1;
					req <= pending_q[0].req;
					pending_q.delete(0);
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (arst_n && done) begin
			if (rsp_due_q.size() == 0) begin
				$error("unexpected result: status %0d count %0d element %0d last %0d",
					result.status, result.count, $signed(result.element), result.last);
				errors++;
			end else begin
				if (result.status !== rsp_due_q[0].status) begin
					$error("status: expected %0d, got %0d", rsp_due_q[0].status,
						result.status);
					errors++;
				end
				if (result.count !== rsp_due_q[0].count) begin
					$error("count: expected %0d, got %0d", rsp_due_q[0].count,
						result.count);
					errors++;
				end
				if (result.element !== rsp_due_q[0].element) begin
					$error("element: expected %0d, got %0d",
						$signed(rsp_due_q[0].element), $signed(result.element));
					errors++;
				end
				if (result.last !== rsp_due_q[0].last) begin
					$error("last: expected %0d, got %0d", rsp_due_q[0].last,
						result.last);
					errors++;
				end
				rsp_due_q.delete(0);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("ordered_list_positional_edit_core regression: fail");
		$finish;
	end

	initial begin
		int n;
		int len;
		mix_t mix;

		queue_req(CMD_DUMP, '0, 0);
		queue_req(CMD_DEL_FIRST, '0, 0);
		queue_req(CMD_DEL_LAST, '0, 0);
		queue_req(CMD_DEL_AT, '0, 0);
		queue_req(CMD_INS_AT, 32'sd5, 2);
		queue_req(CMD_INS_AT, 32'sh7fff_ffff, 0);
		queue_req(CMD_INS_FIRST, 32'sh8000_0000, 0);
		queue_req(CMD_INS_LAST, '0, 0);
		queue_req(CMD_INS_AT, -32'sd1, 4);
		queue_req(CMD_INS_AT, 32'sd9, 17);
		queue_req(CMD_INS_AT, 32'sh5555_aaaa, 2);
		queue_req(CMD_NOP, 32'sh1234_5678, 31);
		queue_req(CMD_DUMP, '0, 0);
		queue_req(CMD_DEL_AT, '0, 17);
		queue_req(CMD_DEL_AT, '0, 6);
		queue_req(CMD_DEL_AT, '0, 5);
		queue_req(CMD_DEL_AT, '0, 0);
		queue_req(CMD_DEL_AT, '0, 2);
		queue_req(CMD_DUMP, '0, 0, 1'b1);
		queue_req(CMD_DEL_LAST, '0, 0);
		queue_req(CMD_DEL_FIRST, '0, 0);
		queue_req(CMD_DUMP, '0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 3; ph++) begin
			wait_drained();
			idle_pct = (ph == 0) ? 6 : (ph == 1) ? 83 : 0;
			n = 0;
			// fill to capacity, then push past it
			while (gen_len < OLPE_CAPACITY) begin
				queue_req(cmd_t'($urandom_range(2, 0)), pick_value(),
					$urandom_range(gen_len + 1, 0), n == 0);
				n++;
			end
			repeat (2) begin
				queue_req(cmd_t'($urandom_range(2, 0)), pick_value(), pick_pos());
				n++;
			end
			queue_req(CMD_DUMP, '0, 0);
			n++;
			while (n < PHASE_ITEMS) begin
				mix = mix_t'($urandom_range(2, 0));
				len = $urandom_range(30, 8);
				repeat (len) begin
					random_req(mix, $urandom_range(99) < 2);
					n++;
				end
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("ordered_list_positional_edit_core regression: pass");
		else
			$display("ordered_list_positional_edit_core regression: fail");
		$finish;
	end

endmodule
